// ===== rtl/dnle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dnle_pkg;

	localparam int IDX_W = 6;
	localparam int STORE_DEPTH = 62;
	localparam logic [7:0] SEPARATOR = 8'h2E;
	localparam logic [7:0] TERMINATOR = 8'h00;

	typedef enum logic [1:0] {
		CMD_CHAR,
		CMD_DOT,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [7:0]       data;
		logic [IDX_W-1:0] idx;
		logic             ovf;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       name_done;
		logic       too_long;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/dns_name_label_encoder_core.sv =====
// Channel  Direction  Handshake           Fields
// input    in         push / full         character, is_end
// result   out        pop / empty         out_byte, run_last, name_done, too_long
//
// The back end writes a character into the label store; for a dot or an end it takes
// the command, then sends the length byte of the pending label, one byte per character
// read from the store and, for an end only, the terminator.
// The front accepts one transaction a cycle while the four-entry command queue has room.
// Reset clears the label count, the overflow flag, all queue pointers and the sequencer.
// The label store is not cleared; only entries written for the current label are read.
// A full result queue stalls the back end, which in turn lets the command queue fill.
`timescale 1ns / 1ps
`default_nettype none

module dns_name_label_encoder_core
	import dnle_pkg::*;
#(
	parameter int LABEL_MAX = 62
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] character,
	input  wire logic       is_end,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            name_done,
	output logic            too_long
);

	cmd_t    cmd_in;
	cmd_t    cmd_out;
	logic    cmd_push;
	logic    cmd_full;
	logic    cmd_pop;
	logic    cmd_empty;
	result_t res_in;
	result_t res_out;
	logic    res_push;
	logic    res_full;

	dnle_front #(
		.LABEL_MAX(LABEL_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.character(character),
		.is_end   (is_end),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	dnle_fifo #(
		.WIDTH($bits(cmd_t)),
		.AW   (2)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_data(cmd_in),
		.full   (cmd_full),
		.rd_en  (cmd_pop),
		.rd_data(cmd_out),
		.empty  (cmd_empty)
	);

	dnle_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_push (res_push),
		.res      (res_in),
		.res_full (res_full)
	);

	dnle_fifo #(
		.WIDTH($bits(result_t)),
		.AW   (1)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_out),
		.empty  (empty)
	);

	assign out_byte  = res_out.out_byte;
	assign run_last  = res_out.run_last;
	assign name_done = res_out.name_done;
	assign too_long  = res_out.too_long;

endmodule

`default_nettype wire

// ===== rtl/dnle_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dnle_fifo #(
	parameter int WIDTH = 8,
	parameter int AW = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	localparam int Depth = 1 << AW;

	logic [WIDTH-1:0] mem_q [Depth];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == (AW+1)'(Depth));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dnle_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dnle_front
	import dnle_pkg::*;
#(
	parameter int LABEL_MAX = 62
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] character,
	input  wire logic       is_end,
	output logic            cmd_push,
	output cmd_t            cmd,
	input  wire logic       cmd_full
);

	localparam logic [IDX_W-1:0] LabelMaxC = IDX_W'(LABEL_MAX);

	logic [IDX_W-1:0] count_q;
	logic             ovf_q;
	logic             take;
	logic             is_dot;
	logic             has_room;

	assign full     = cmd_full;
	assign take     = push && !cmd_full;
	assign is_dot   = !is_end && (character == SEPARATOR);
	assign has_room = (count_q < LabelMaxC);

	always_comb begin
		cmd.data = character;
		cmd.idx  = count_q;
		cmd.ovf  = ovf_q;
		if (is_end) begin
			cmd.kind = CMD_END;
		end else if (is_dot) begin
			cmd.kind = CMD_DOT;
		end else begin
			cmd.kind = CMD_CHAR;
		end
		cmd_push = take && (is_end || is_dot || has_room);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (is_end || is_dot) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (has_room) begin
				count_q <= count_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LabelMaxC)
		else $error("label count exceeds the label limit");
`endif

endmodule

`default_nettype wire

// ===== rtl/dnle_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dnle_back
	import dnle_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic cmd_empty,
	output logic      cmd_pop,
	output logic      res_push,
	output result_t   res,
	input  wire logic res_full
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEN,
		ST_CHARS,
		ST_TERM
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] len_q;
	logic [IDX_W-1:0] idx_q;
	logic             ovf_q;
	logic             end_q;
	logic [7:0]       store_q [STORE_DEPTH];
	logic [7:0]       rdata_q;
	logic [IDX_W-1:0] raddr;
	logic             last_char;
	logic             store_wr;

	assign cmd_pop   = (state_q == ST_IDLE) && !cmd_empty;
	assign store_wr  = cmd_pop && (cmd.kind == CMD_CHAR);
	assign last_char = (idx_q == len_q - 1'b1);

	always_comb begin
		res      = '0;
		res_push = 1'b0;
		raddr    = '0;
		case (state_q)
			ST_LEN: begin
				res.out_byte = 8'(len_q);
				res.run_last = !end_q && (len_q == '0);
				res.too_long = ovf_q;
				res_push     = !res_full;
			end
			ST_CHARS: begin
				res.out_byte = rdata_q;
				res.run_last = !end_q && last_char;
				res_push     = !res_full;
				if (res_push && !last_char) begin
					raddr = idx_q + 1'b1;
				end else if (!res_push) begin
					raddr = idx_q;
				end
			end
			ST_TERM: begin
				res.out_byte  = TERMINATOR;
				res.run_last  = 1'b1;
				res.name_done = 1'b1;
				res_push      = !res_full;
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (store_wr) begin
			store_q[cmd.idx] <= cmd.data;
		end
		rdata_q <= store_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			idx_q   <= '0;
			ovf_q   <= 1'b0;
			end_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop && cmd.kind != CMD_CHAR) begin
						len_q   <= cmd.idx;
						ovf_q   <= cmd.ovf;
						end_q   <= (cmd.kind == CMD_END);
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (res_push) begin
						idx_q <= '0;
						if (len_q != '0) begin
							state_q <= ST_CHARS;
						end else if (end_q) begin
							state_q <= ST_TERM;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CHARS: begin
					if (res_push) begin
						if (!last_char) begin
							idx_q <= idx_q + 1'b1;
						end else if (end_q) begin
							state_q <= ST_TERM;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_TERM: begin
					if (res_push) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_idx_in_label: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHARS) |-> (idx_q < len_q))
		else $error("character index runs past the label length");
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.name_done) |-> res.run_last)
		else $error("terminator is not the last result of its transaction");
	a_empty_label: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEN && res_push && len_q == '0) |=> (state_q != ST_CHARS))
		else $error("empty label entered the character phase");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_dns_name_label_encoder_core.sv =====
`timescale 1ns / 1ps

module tb_dns_name_label_encoder_core;
	import dnle_pkg::*;

	localparam int LABEL_MAX = 62;
	localparam int IDLE_PCT = 13;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] character = 8'h00;
	logic       is_end = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;
	logic       name_done;
	logic       too_long;

	result_t    wire_bytes_q[$];
	logic [7:0] label_chars[LABEL_MAX];
	int         label_len = 0;
	logic       label_trunc = 1'b0;

	int errors = 0;
	int items_sent = 0;
	int bytes_checked = 0;
	int names_ended = 0;
	int truncated_labels = 0;
	int hold_left = 0;
	bit quiet = 1'b0;

	dns_name_label_encoder_core #(
		.LABEL_MAX(LABEL_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.character(character),
		.is_end(is_end),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.run_last(run_last),
		.name_done(name_done),
		.too_long(too_long)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL dns_name_label_encoder_core");
		$finish;
	end

	function automatic void encode_item(input logic [7:0] ch, input logic fin);
		int n;
		result_t r;
		if (fin || ch == SEPARATOR) begin
			n = label_len;
			r.out_byte = 8'(n);
			r.run_last = !fin && n == 0;
			r.name_done = 1'b0;
			r.too_long = label_trunc;
			wire_bytes_q.push_back(r);
			if (label_trunc)
				truncated_labels++;
			for (int k = 0; k < n; k++) begin
				r.out_byte = label_chars[k];
				r.run_last = !fin && k == n - 1;
				r.too_long = 1'b0;
				wire_bytes_q.push_back(r);
			end
			label_len = 0;
			label_trunc = 1'b0;
			if (fin) begin
				r = '{TERMINATOR, 1'b1, 1'b1, 1'b0};
				wire_bytes_q.push_back(r);
				names_ended++;
			end
		end else if (label_len < LABEL_MAX) begin
			label_chars[label_len] = ch;
			label_len++;
		end else begin
			label_trunc = 1'b1;
		end
	endfunction

	function automatic logic [7:0] label_byte();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c == SEPARATOR)
			c = 8'h2D;
		return c;
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic fin);
		if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		character <= ch;
		is_end <= fin;
		do @(posedge clk); while (full !== 1'b0);
		encode_item(ch, fin);
		items_sent++;
	endtask

	task automatic send_label(input int len);
		for (int k = 0; k < len; k++)
			send_char(label_byte(), 1'b0);
	endtask

	task automatic send_random_name();
		int labels;
		int len;
		labels = $urandom_range(1, 4);
		for (int l = 0; l < labels; l++) begin
			if ($urandom_range(0, 49) == 0)
				len = $urandom_range(LABEL_MAX - 4, LABEL_MAX + 4);
			else
				len = $urandom_range(0, 10);
			send_label(len);
			if (l < labels - 1)
				send_char(SEPARATOR, 1'b0);
		end
		case ($urandom_range(0, 9))
			0: send_char(SEPARATOR, 1'b0);
			1: ;
			2: begin
				send_char(SEPARATOR, 1'b0);
				send_char(8'($urandom_range(0, 255)), 1'b1);
			end
			default: send_char(8'($urandom_range(0, 255)), 1'b1);
		endcase
	endtask

	task automatic wait_for_results();
		push <= 1'b0;
		while (wire_bytes_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_char(8'h00, 1'b1);
		send_char(SEPARATOR, 1'b0);
		send_char(SEPARATOR, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h2D, 1'b0);
		send_char(8'h2F, 1'b0);
		send_char(SEPARATOR, 1'b0);
		send_char(8'h7F, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(SEPARATOR, 1'b0);
		send_char(SEPARATOR, 1'b1);
		send_char(8'h61, 1'b0);
		send_char(8'hFF, 1'b1);
		send_char(8'h55, 1'b0);
		send_char(8'hAA, 1'b0);
		send_char(8'h00, 1'b1);
		wait_for_results();
	endtask

	task automatic test_overlong_labels();
		send_label(LABEL_MAX);
		send_char(SEPARATOR, 1'b0);
		send_label(LABEL_MAX + 1);
		send_char(8'h00, 1'b1);
		send_char(SEPARATOR, 1'b0);
		send_char(SEPARATOR, 1'b1);
		wait_for_results();
	endtask

	task automatic test_backpressure();
		@(negedge clk);
		hold_left = 400;
		@(posedge clk);
		for (int l = 0; l < 20; l++) begin
			send_label($urandom_range(0, 3));
			send_char(SEPARATOR, 1'b0);
		end
		send_char(8'h00, 1'b1);
		wait_for_results();
	endtask

	task automatic test_quiet_burst();
		int stop_at;
		stop_at = items_sent + 30;
		quiet = 1'b1;
		while (items_sent < stop_at)
			send_random_name();
		send_char(8'h00, 1'b1);
		wait_for_results();
		quiet = 1'b0;
	endtask

	task automatic test_random_names();
		int stop_at;
		stop_at = items_sent + 60;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 9) == 0)
				send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
			else
				send_random_name();
		end
		send_char(8'h00, 1'b1);
		wait_for_results();
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (pop && empty === 1'b0) begin
			if (wire_bytes_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, expected none, actual byte %h",
					$time, out_byte);
			end else begin
				want = wire_bytes_q.pop_front();
				bytes_checked++;
				if (out_byte !== want.out_byte) begin
					errors++;
					$display("%0t: out_byte expected %h actual %h",
						$time, want.out_byte, out_byte);
				end
				if (run_last !== want.run_last) begin
					errors++;
					$display("%0t: run_last expected %b actual %b",
						$time, want.run_last, run_last);
				end
				if (name_done !== want.name_done) begin
					errors++;
					$display("%0t: name_done expected %b actual %b",
						$time, want.name_done, name_done);
				end
				if (too_long !== want.too_long) begin
					errors++;
					$display("%0t: too_long expected %b actual %b",
						$time, want.too_long, too_long);
				end
			end
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			pop <= 1'b0;
			hold_left--;
		end else begin
			pop <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overlong_labels();
		test_backpressure();
		test_quiet_burst();
		test_random_names();
		wait_for_results();
		repeat (20) @(posedge clk);
		$display("Sent %0d characters and end marks forming %0d names.", items_sent, names_ended);
		$display("Checked %0d output bytes, %0d of them length bytes of truncated labels.",
			bytes_checked, truncated_labels);
		if (errors == 0)
			$display("PASS dns_name_label_encoder_core");
		else
			$display("FAIL dns_name_label_encoder_core");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/dnle_pkg.sv
rtl/dnle_fifo.sv
rtl/dnle_front.sv
rtl/dnle_back.sv
rtl/dns_name_label_encoder_core.sv
verif/tb_dns_name_label_encoder_core.sv
